// ----- rtl/wspt_pkg.sv -----
package wspt_pkg;

  localparam int MacW = 48;

  // request kinds
  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // result status codes
  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_KNOWN   = 3'd1;
  localparam logic [2:0] ST_ADDED   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;
  localparam logic [2:0] ST_BAD     = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  // frame control codes
  localparam logic [1:0] FT_MGMT = 2'd0;
  localparam logic [1:0] FT_DATA = 2'd2;
  localparam logic [1:0] PC_MGMT = 2'd0;
  localparam logic [1:0] PC_DATA = 2'd2;

  localparam logic [MacW-1:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [1:0]      pkt_class;
    logic [11:0]     frame_len;
    logic [15:0]     fc_word;
    logic [MacW-1:0] addr1;
    logic [MacW-1:0] addr2;
    logic [MacW-1:0] addr3;
    logic [5:0]      entry_index;
    logic [MacW-1:0] entry_bssid;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [MacW-1:0] sta_addr;
    logic [MacW-1:0] station_bssid;
    logic [5:0]      ap_match_index;
    logic [6:0]      station_total;
  } rsp_t;

  function automatic logic is_group(input logic [MacW-1:0] a);
    return a[0] || (a == MAC_BCAST);
  endfunction

  function automatic logic mgmt_kept(input logic [3:0] st);
    return (st <= 4'h3) || ((st >= 4'hA) && (st <= 4'hD));
  endfunction

  // station pick for one candidate bssid; bit MacW is the found flag
  function automatic logic [MacW:0] pick_station(
    input logic [1:0] ftype, input logic to_ds, input logic from_ds,
    input logic [MacW-1:0] a1, input logic [MacW-1:0] a2,
    input logic [MacW-1:0] a3, input logic [MacW-1:0] b);
    logic            found;
    logic [MacW-1:0] c;
    found = 1'b0;
    c = '0;
    if (ftype == FT_DATA) begin
      if (to_ds && !from_ds) begin
        if (a1 == b) begin c = a2; found = 1'b1; end
      end else if (!to_ds && from_ds) begin
        if (a2 == b) begin c = a1; found = 1'b1; end
      end else if (!to_ds && !from_ds && a3 == b) begin
        if (a2 != b && !is_group(a2)) begin c = a2; found = 1'b1; end
        else if (a1 != b && !is_group(a1)) begin c = a1; found = 1'b1; end
      end
    end else begin
      if (a1 == b && a2 != b) begin c = a2; found = 1'b1; end
      else if (a2 == b && a1 != b) begin c = a1; found = 1'b1; end
      else if (a3 == b) begin
        if (a2 != b && !is_group(a2)) begin c = a2; found = 1'b1; end
        else if (a1 != b && !is_group(a1)) begin c = a1; found = 1'b1; end
      end
    end
    if (!found || is_group(c) || c == b) found = 1'b0;
    return {found, c};
  endfunction

endpackage

// ----- rtl/wspt_req_if.sv -----
interface wspt_req_if;
  import wspt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/wspt_rsp_if.sv -----
interface wspt_rsp_if;
  import wspt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/wspt_ram.sv -----
module wspt_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/wifi_station_pair_tracker_core.sv -----
// channel  dir  beat contents
// req      in   req_type, pkt_class, frame_len, fc_word, addr1..3, entry_index/bssid
// rsp      out  status, sta_addr, station_bssid, ap_match_index, station_total
// apb      in   reg 0 ap_limit @0x0, reg 1 min_header_len @0x4
//
// a frame goes from accept to result through each ap slot tried (read, compare),
// then through each stored pair checked (read, compare); load and read pass S_RDW
// and S_OUT, clear sets its result on accept. clear only zeroes the pair count (entries
// above it are never read). reset is synchronous; no clearing pass is needed. the
// result is held in an output register; the next request is taken once it is accepted.
module wifi_station_pair_tracker_core #(
  parameter int AP_TABLE_DEPTH      = 64,
  parameter int STATION_TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  wspt_req_if.sink    req,
  wspt_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wspt_pkg::*;

  localparam int ApW = $clog2(AP_TABLE_DEPTH) > 0 ? $clog2(AP_TABLE_DEPTH) : 1;
  localparam int StW = $clog2(STATION_TABLE_DEPTH) > 0 ? $clog2(STATION_TABLE_DEPTH) : 1;
  localparam int ApCW = $clog2(AP_TABLE_DEPTH + 1);
  localparam int StCW = $clog2(STATION_TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APRD  = 3'd1;
  localparam logic [2:0] S_APCHK = 3'd2;
  localparam logic [2:0] S_PRRD  = 3'd3;
  localparam logic [2:0] S_PRCHK = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [0:0] REG_AP_LIMIT = 1'b0;
  localparam logic [0:0] REG_MIN_LEN  = 1'b1;

  logic [6:0]  ap_limit;
  logic [11:0] min_header_len;
  logic [2:0]  state;
  req_t        cur;
  logic [ApCW-1:0] ap_n;
  logic [ApCW-1:0] ap_i;
  logic [StCW-1:0] pr_k;
  logic [StCW-1:0] pair_count;
  logic [MacW-1:0] found_sta;
  logic [MacW-1:0] found_bss;
  rsp_t out_q;
  logic out_valid;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ap_limit <= 7'd0;
      min_header_len <= 12'd24;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_AP_LIMIT: ap_limit <= pwdata[6:0];
        REG_MIN_LEN:  min_header_len <= pwdata[11:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[2])
      REG_AP_LIMIT: prdata = {25'd0, ap_limit};
      REG_MIN_LEN:  prdata = {20'd0, min_header_len};
      default:      prdata = '0;
    endcase
  end

  // saturated ap count
  logic [ApCW-1:0] ap_sat;
  always_comb begin
    if (32'(ap_limit) > AP_TABLE_DEPTH) ap_sat = ApCW'(AP_TABLE_DEPTH);
    else ap_sat = ApCW'(ap_limit);
  end

  // memories
  logic            ap_we;
  logic [ApW-1:0]  ap_raddr;
  logic [MacW-1:0] ap_rdata;
  logic            pr_we;
  logic [StW-1:0]  pr_waddr;
  logic [StW-1:0]  pr_raddr;
  logic [MacW-1:0] sta_rdata;
  logic [MacW-1:0] bss_rdata;

  wspt_ram #(.Width(MacW), .Depth(AP_TABLE_DEPTH)) u_ap_ram (
    .clk(clk), .we(ap_we), .waddr(ApW'(cur.entry_index)),
    .wdata(cur.entry_bssid), .raddr(ap_raddr), .rdata(ap_rdata));
  wspt_ram #(.Width(MacW), .Depth(STATION_TABLE_DEPTH)) u_sta_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(found_sta),
    .raddr(pr_raddr), .rdata(sta_rdata));
  wspt_ram #(.Width(MacW), .Depth(STATION_TABLE_DEPTH)) u_bss_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(found_bss),
    .raddr(pr_raddr), .rdata(bss_rdata));

  assign ap_raddr = ap_i[ApW-1:0];
  assign pr_waddr = pair_count[StW-1:0];

  // frame filter
  logic [1:0] ftype;
  logic       keep;
  assign ftype = cur.fc_word[3:2];
  assign keep = (cur.pkt_class == PC_MGMT || cur.pkt_class == PC_DATA) && ap_n != '0 &&
                cur.frame_len >= min_header_len &&
                (ftype == FT_DATA || (ftype == FT_MGMT && mgmt_kept(cur.fc_word[7:4])));

  logic [MacW:0] pick;
  assign pick = pick_station(ftype, cur.fc_word[8], cur.fc_word[9],
                             cur.addr1, cur.addr2, cur.addr3, ap_rdata);

  logic idx_ap_ok;
  logic idx_rd_ok;
  assign idx_ap_ok = 32'(cur.entry_index) < AP_TABLE_DEPTH;
  assign idx_rd_ok = 32'(cur.entry_index) < 32'(pair_count) &&
                     32'(cur.entry_index) < STATION_TABLE_DEPTH;

  always_comb begin
    pr_raddr = pr_k[StW-1:0];
    if (state == S_IDLE) pr_raddr = StW'(req.data.entry_index);
  end

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data = out_q;

  // ap load writes while its result is formed
  assign ap_we = (state == S_RDW) && (cur.req_type == REQ_LOAD) && idx_ap_ok;
  assign pr_we = (state == S_PRRD) && (pr_k == pair_count) &&
                 (32'(pair_count) < STATION_TABLE_DEPTH);

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pair_count <= '0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            ap_i <= '0;
            pr_k <= '0;
            ap_n <= ap_sat;
            case (req.data.req_type)
              REQ_FRAME: begin
                out_q <= '0;
                state <= S_APRD;
              end
              REQ_LOAD, REQ_READ: begin
                out_q <= '0;
                state <= S_RDW;
              end
              default: begin
                pair_count <= '0;
                out_q.status <= ST_DONE;
                out_q.sta_addr <= '0;
                out_q.station_bssid <= '0;
                out_q.ap_match_index <= '0;
                out_q.station_total <= 7'd0;
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RDW: begin
          out_q.station_total <= 7'(pair_count);
          if (cur.req_type == REQ_LOAD) begin
            out_q.status <= idx_ap_ok ? ST_DONE : ST_BAD;
          end else if (idx_rd_ok) begin
            out_q.status <= ST_READ;
            out_q.sta_addr <= sta_rdata;
            out_q.station_bssid <= bss_rdata;
          end else begin
            out_q.status <= ST_BAD;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_APRD: begin
          if (!keep || ap_i >= ap_n) begin
            out_q.status <= ST_IGNORED;
            out_q.station_total <= 7'(pair_count);
            state <= S_OUT;
          end else begin
            state <= S_APCHK;
          end
        end
        S_APCHK: begin
          if (pick[MacW]) begin
            found_sta <= pick[MacW-1:0];
            found_bss <= ap_rdata;
            out_q.ap_match_index <= 6'(ap_i);
            out_q.sta_addr <= pick[MacW-1:0];
            out_q.station_bssid <= ap_rdata;
            state <= S_PRRD;
          end else begin
            ap_i <= ap_i + 1'b1;
            state <= S_APRD;
          end
        end
        S_PRRD: begin
          if (pr_k == pair_count) begin
            if (32'(pair_count) < STATION_TABLE_DEPTH) begin
              pair_count <= pair_count + 1'b1;
              out_q.status <= ST_ADDED;
              out_q.station_total <= 7'(pair_count + 1'b1);
            end else begin
              out_q.status <= ST_FULL;
              out_q.station_total <= 7'(pair_count);
            end
            state <= S_OUT;
          end else begin
            state <= S_PRCHK;
          end
        end
        S_PRCHK: begin
          if (sta_rdata == found_sta && bss_rdata == found_bss) begin
            out_q.status <= ST_KNOWN;
            out_q.station_total <= 7'(pair_count);
            state <= S_OUT;
          end else begin
            pr_k <= pr_k + 1'b1;
            state <= S_PRRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/wspt_checker.sv -----
module wspt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [6:0] station_total
);
  import wspt_pkg::*;

  // one request in flight: no accept while a result waits
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !out_valid) else $error("accept while result pending");

  // status stays within the defined codes
  a_clr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_DONE) else $error("status out of range");

  // added pairs report a nonzero total
  a_add: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ADDED) |-> station_total != 7'd0)
    else $error("added with empty total");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(status))
    else $error("result dropped");
endmodule

bind wifi_station_pair_tracker_core wspt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .status(rsp.data.status),
  .station_total(rsp.data.station_total));

// ----- sim/wifi_station_pair_tracker_core_tb.sv -----
`timescale 1ns / 1ps

module wifi_station_pair_tracker_core_tb;
  import wspt_pkg::*;

  localparam int Depth = 64;
  localparam int IdleWait = 300;
  localparam logic [2:0] ADDR_AP_LIMIT = 3'd0;
  localparam logic [2:0] ADDR_MIN_LEN  = 3'd4;
  // management subtypes: the bounds of the kept ranges, and beacon, which is not kept
  localparam logic [3:0] SUB_ASSOC_REQ   = 4'h0;
  localparam logic [3:0] SUB_REASSOC_RSP = 4'h3;
  localparam logic [3:0] SUB_DISASSOC    = 4'hA;
  localparam logic [3:0] SUB_ACTION      = 4'hD;
  localparam logic [3:0] SUB_BEACON      = 4'h8;
  localparam logic [1:0] FT_CTRL = 2'd1;

  // expected pair table behavior and queue of predicted beats
  class pair_scoreboard;
    rsp_t        pending_q[$];
    int          errors;
    logic [47:0] ap_tab[Depth];
    logic [47:0] sta_tab[Depth];
    logic [47:0] bss_tab[Depth];
    int unsigned n_pairs;
    int unsigned ap_cnt;
    int unsigned min_len;

    function new();
      errors = 0;
      n_pairs = 0;
      ap_cnt = 0;
      min_len = 24;
      foreach (ap_tab[i]) begin
        ap_tab[i] = '0;
        sta_tab[i] = '0;
        bss_tab[i] = '0;
      end
    endfunction

    function bit group_addr(logic [47:0] a);
      return a[0] || (a == MAC_BCAST);
    endfunction

    // station address for one candidate bssid
    function bit find_client(logic [1:0] ft, bit tods, bit fromds, logic [47:0] a1,
                             logic [47:0] a2, logic [47:0] a3, logic [47:0] b,
                             output logic [47:0] sta);
      bit hit;
      logic [47:0] c;
      hit = 0;
      c = '0;
      if (ft == FT_DATA) begin
        if (tods && !fromds) begin
          if (a1 == b) begin c = a2; hit = 1; end
        end else if (!tods && fromds) begin
          if (a2 == b) begin c = a1; hit = 1; end
        end else if (!tods && !fromds && a3 == b) begin
          if (a2 != b && !group_addr(a2)) begin c = a2; hit = 1; end
          else if (a1 != b && !group_addr(a1)) begin c = a1; hit = 1; end
        end
      end else begin
        if (a1 == b && a2 != b) begin c = a2; hit = 1; end
        else if (a2 == b && a1 != b) begin c = a1; hit = 1; end
        else if (a3 == b) begin
          if (a2 != b && !group_addr(a2)) begin c = a2; hit = 1; end
          else if (a1 != b && !group_addr(a1)) begin c = a1; hit = 1; end
        end
      end
      sta = c;
      return hit && !group_addr(c) && c != b;
    endfunction

    function void note(req_t r);
      rsp_t e;
      logic [1:0] ft;
      logic [3:0] sub;
      int unsigned n;
      bit keep;
      bit known;
      logic [47:0] sta;
      e = '0;
      case (r.req_type)
        REQ_FRAME: begin
          ft = r.fc_word[3:2];
          sub = r.fc_word[7:4];
          n = (ap_cnt > Depth) ? Depth : ap_cnt;
          keep = (r.pkt_class == PC_MGMT || r.pkt_class == PC_DATA) && n != 0 &&
                 r.frame_len >= min_len &&
                 (ft == FT_DATA || (ft == FT_MGMT && (sub <= SUB_REASSOC_RSP ||
                  (sub >= SUB_DISASSOC && sub <= SUB_ACTION))));
          if (keep) begin
            for (int i = 0; i < n; i++) begin
              if (find_client(ft, r.fc_word[8], r.fc_word[9], r.addr1, r.addr2,
                              r.addr3, ap_tab[i], sta)) begin
                known = 0;
                e.sta_addr = sta;
                e.station_bssid = ap_tab[i];
                e.ap_match_index = 6'(i);
                for (int k = 0; k < n_pairs; k++)
                  if (sta_tab[k] == sta && bss_tab[k] == ap_tab[i]) known = 1;
                if (known) begin
                  e.status = ST_KNOWN;
                end else if (n_pairs < Depth) begin
                  sta_tab[n_pairs] = sta;
                  bss_tab[n_pairs] = ap_tab[i];
                  n_pairs++;
                  e.status = ST_ADDED;
                end else begin
                  e.status = ST_FULL;
                end
                break;
              end
            end
          end
          if (e.status == ST_IGNORED) begin
            e.sta_addr = '0;
            e.station_bssid = '0;
            e.ap_match_index = '0;
          end
        end
        REQ_LOAD: begin
          ap_tab[r.entry_index] = r.entry_bssid;
          e.status = ST_DONE;
        end
        REQ_READ: begin
          if (r.entry_index < n_pairs) begin
            e.sta_addr = sta_tab[r.entry_index];
            e.station_bssid = bss_tab[r.entry_index];
            e.status = ST_READ;
          end else begin
            e.status = ST_BAD;
          end
        end
        default: begin
          n_pairs = 0;
          e.status = ST_DONE;
        end
      endcase
      e.station_total = 7'(n_pairs);
      pending_q.push_back(e);
    endfunction

    function void check(rsp_t got);
      rsp_t e;
      if (pending_q.size() == 0) begin
        if (errors < 10) $display("unexpected beat %p", got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got !== e) begin
        if (errors < 10) begin
          $display("beat mismatch: exp st=%0d mac=%h bss=%h idx=%0d tot=%0d",
                   e.status, e.sta_addr, e.station_bssid, e.ap_match_index,
                   e.station_total);
          $display("               got st=%0d mac=%h bss=%h idx=%0d tot=%0d",
                   got.status, got.sta_addr, got.station_bssid,
                   got.ap_match_index, got.station_total);
        end
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  wspt_req_if req_ch();
  wspt_rsp_if rsp_ch();

  wifi_station_pair_tracker_core u_top (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pair_scoreboard sb = new();
  bit loaded[Depth];
  logic [47:0] sta_pool[16];
  int burst_left = 0;
  int unsigned cyc = 0;
  int stall_mode = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 97 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      default: rsp_ch.ready <= (cyc[2:0] > 2);
    endcase
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check(rsp_ch.data);
  end

  task automatic send(req_t r);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    sb.note(r);
    if (r.req_type == REQ_LOAD) loaded[r.entry_index] = 1;
    // bursts with random gaps between them
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] a, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (a == ADDR_AP_LIMIT) sb.ap_cnt = v[6:0];
    else sb.min_len = v[11:0];
  endtask

  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < Depth && loaded[n]) n++;
    return n;
  endfunction

  function automatic req_t blank(logic [1:0] kind);
    req_t r;
    r = '0;
    r.req_type = kind;
    return r;
  endfunction

  function automatic req_t load_req(int idx, logic [47:0] b);
    req_t r;
    r = blank(REQ_LOAD);
    r.entry_index = 6'(idx);
    r.entry_bssid = b;
    return r;
  endfunction

  function automatic req_t frame_req(logic [1:0] pc, logic [1:0] ft, logic [3:0] sub,
                                     bit tods, bit fromds, logic [47:0] a1,
                                     logic [47:0] a2, logic [47:0] a3, int len);
    req_t r;
    r = blank(REQ_FRAME);
    r.pkt_class = pc;
    r.frame_len = 12'(len);
    r.fc_word = 16'($urandom()) & 16'hFC03;
    r.fc_word[3:2] = ft;
    r.fc_word[7:4] = sub;
    r.fc_word[8] = tods;
    r.fc_word[9] = fromds;
    r.addr1 = a1;
    r.addr2 = a2;
    r.addr3 = a3;
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] unicast_mac();
    logic [47:0] m;
    m = rand_mac();
    m[0] = 1'b0;
    return m;
  endfunction

  // mostly well-formed header toward an ap slot within the ap count, random role layout
  function automatic req_t good_frame();
    req_t r;
    logic [47:0] b, s, o;
    int n, len;
    logic [3:0] sub;
    n = (sb.ap_cnt > Depth) ? Depth : sb.ap_cnt;
    b = sb.ap_tab[$urandom_range(0, (n == 0) ? 0 : n - 1)];
    s = sta_pool[$urandom_range(0, 15)];
    o = ($urandom_range(0, 1) != 0) ? MAC_BCAST : unicast_mac();
    len = $urandom_range(sb.min_len, 4095);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 4095);
    sub = ($urandom_range(0, 1) != 0) ?
          4'($urandom_range(SUB_ASSOC_REQ, SUB_REASSOC_RSP)) :
          4'($urandom_range(SUB_DISASSOC, SUB_ACTION));
    case ($urandom_range(0, 6))
      0: r = frame_req(PC_MGMT, FT_MGMT, sub, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), b, s, b, len);
      1: r = frame_req(PC_MGMT, FT_MGMT, sub, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), s, b, b, len);
      2: r = frame_req(PC_MGMT, FT_MGMT, sub, 0, 0, o, s, b, len);
      3: r = frame_req(PC_DATA, FT_DATA, 4'($urandom_range(0, 15)), 1, 0, b, s, o, len);
      4: r = frame_req(PC_DATA, FT_DATA, 4'($urandom_range(0, 15)), 0, 1, s, b, o, len);
      5: r = frame_req(PC_DATA, FT_DATA, 4'($urandom_range(0, 15)), 0, 0, o, s, b, len);
      default: r = frame_req(PC_DATA, FT_DATA, 4'($urandom_range(0, 15)), 0, 0, s, o, b,
                             len);
    endcase
    return r;
  endfunction

  task automatic random_items(int count);
    req_t r;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        r = good_frame();
      end else if (pick < 76) begin
        r = load_req($urandom_range(0, Depth - 1),
                     ($urandom_range(0, 1) != 0) ? unicast_mac() : rand_mac());
      end else if (pick < 86) begin
        r = blank(REQ_READ);
        r.entry_index = 6'($urandom_range(0, Depth - 1));
        r.pkt_class = 2'($urandom_range(0, 3));
      end else if (pick < 88) begin
        r = blank(REQ_CLEAR);
      end else begin
        // noise: any header contents
        r = blank(REQ_FRAME);
        r.pkt_class = 2'($urandom_range(0, 3));
        r.frame_len = 12'($urandom_range(0, 4095));
        r.fc_word = 16'($urandom_range(0, 65535));
        r.addr1 = rand_mac();
        r.addr2 = rand_mac();
        r.addr3 = rand_mac();
        r.entry_index = 6'($urandom_range(0, Depth - 1));
        r.entry_bssid = rand_mac();
      end
      send(r);
    end
  endtask

  task automatic load_all();
    for (int i = 0; i < Depth; i++) send(load_req(i, unicast_mac()));
  endtask

  logic [47:0] ap0, ap1, s0, s1;

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    foreach (loaded[i]) loaded[i] = 0;
    foreach (sta_pool[i]) sta_pool[i] = unicast_mac();
    sta_pool[15] = MAC_BCAST;
    sta_pool[14][0] = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero ap count, loads, each role layout and reject case
    ap0 = 48'h0000_0000_0002;
    ap1 = 48'hFFFF_FFFF_FFFE;
    s0 = 48'h0000_0000_0000;
    s1 = 48'h7FFF_FFFF_FFFE;
    send(frame_req(PC_MGMT, FT_MGMT, SUB_ASSOC_REQ, 0, 0, ap0, s1, ap0, 4095));
    send(load_req(0, ap0));
    send(load_req(1, ap1));
    send(load_req(Depth - 1, 48'hFFFF_FFFF_FFFF));
    drain();
    reg_write(ADDR_AP_LIMIT, 2);
    send(frame_req(PC_MGMT, FT_MGMT, SUB_ASSOC_REQ, 0, 0, ap0, s1, ap0, 24));
    send(frame_req(PC_MGMT, FT_MGMT, SUB_ASSOC_REQ, 0, 0, ap0, s1, ap0, 24));
    send(frame_req(PC_MGMT, FT_MGMT, SUB_ACTION, 0, 0, s0, ap1, 48'h1, 100));
    send(frame_req(PC_DATA, FT_DATA, 4'hF, 1, 0, ap1, s1, s0, 4095));
    send(frame_req(PC_DATA, FT_DATA, 4'h0, 0, 1, s0, ap0, s1, 60));
    send(frame_req(PC_DATA, FT_DATA, 4'h0, 1, 1, ap0, s1, ap0, 60));
    send(frame_req(PC_DATA, FT_DATA, 4'h0, 0, 0, MAC_BCAST, 48'h3, ap1, 60));
    send(frame_req(PC_DATA, FT_DATA, 4'h0, 0, 0, 48'h4, MAC_BCAST, ap1, 60));
    send(frame_req(PC_MGMT, FT_MGMT, SUB_BEACON, 0, 0, ap0, 48'h6, ap0, 60));
    send(frame_req(PC_MGMT, FT_CTRL, SUB_ASSOC_REQ, 0, 0, ap0, 48'h6, ap0, 60));
    send(frame_req(2'd1, FT_MGMT, SUB_ASSOC_REQ, 0, 0, ap0, 48'h6, ap0, 60));
    send(frame_req(2'd3, FT_DATA, SUB_ASSOC_REQ, 1, 0, ap0, 48'h6, ap0, 60));
    send(frame_req(PC_MGMT, FT_MGMT, SUB_ASSOC_REQ, 0, 0, ap0, 48'h6, ap0, 23));
    send(blank(REQ_READ));
    send(load_req(0, ap0));
    r_read_last();
    send(blank(REQ_CLEAR));
    send(blank(REQ_READ));
    drain();

    // random phases over register settings
    reg_write(ADDR_AP_LIMIT, 1);
    reg_write(ADDR_MIN_LEN, 0);
    random_items(50);
    drain();
    reg_write(ADDR_AP_LIMIT, loaded_prefix());
    reg_write(ADDR_MIN_LEN, 24);
    random_items(50);
    drain();
    reg_write(ADDR_AP_LIMIT, 0);
    random_items(15);
    load_all();
    drain();
    reg_write(ADDR_AP_LIMIT, 64);
    reg_write(ADDR_MIN_LEN, 30);
    random_items(70);
    drain();
    reg_write(ADDR_AP_LIMIT, 127);
    reg_write(ADDR_MIN_LEN, 4095);
    random_items(25);
    drain();
    reg_write(ADDR_AP_LIMIT, $urandom_range(1, 64));
    reg_write(ADDR_MIN_LEN, $urandom_range(0, 200));
    random_items(50);
    drain();
    // fill the pair table with distinct stations on the full ap table
    reg_write(ADDR_AP_LIMIT, 64);
    reg_write(ADDR_MIN_LEN, 24);
    send(blank(REQ_CLEAR));
    for (int i = 0; i < 70; i++)
      send(frame_req(PC_DATA, FT_DATA, 4'h0, 1, 0, sb.ap_tab[i % Depth], unicast_mac(),
                     s0, 24));
    random_items(40);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // read back the newest stored pair
  task automatic r_read_last();
    req_t r;
    r = blank(REQ_READ);
    r.entry_index = 6'((sb.n_pairs == 0) ? 0 : sb.n_pairs - 1);
    send(r);
  endtask

endmodule

// ----- filelist.f -----
rtl/wspt_pkg.sv
rtl/wspt_req_if.sv
rtl/wspt_rsp_if.sv
rtl/wspt_ram.sv
rtl/wifi_station_pair_tracker_core.sv
rtl/wspt_checker.sv
sim/wifi_station_pair_tracker_core_tb.sv
